// ===== design/quic_stream_frame_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// quic_stream_frame_encoder_assert
// Assertion macros for the stream frame encoder checker.
// ----------------------------------------------------------------------------
`ifndef QUIC_STREAM_FRAME_ENCODER_ASSERT_SVH
`define QUIC_STREAM_FRAME_ENCODER_ASSERT_SVH

// checked property, switched off while reset is held
`define QSFE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property that also holds across reset
`define QSFE_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/qsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// qsfe_pkg
// Types, constants and varint helpers shared by the stream frame encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qsfe_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] LEN_MASK = 16'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [63:0] VARINT_MAX = 64'h3FFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] TYPE_RST_STRM  = 8'h04;
  localparam logic [7:0] TYPE_STOP_SEND = 8'h05;
  localparam logic [7:0] TYPE_STREAM    = 8'h08;
  localparam logic [7:0] TYPE_BIT_OFF   = 8'h04;
  localparam logic [7:0] TYPE_BIT_LEN   = 8'h02;

  typedef enum logic [1:0] {
    CMD_RST_STRM   = 2'd0,
    CMD_STOP_SEND  = 2'd1,
    CMD_STREAM_HDR = 2'd2,
    CMD_PAYLOAD    = 2'd3
  } qsfe_cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_ROOM   = 2'd2,
    ST_STRAY     = 2'd3
  } qsfe_status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] strm_id;
    logic [63:0] app_err;
    logic [63:0] final_sz;
    logic [63:0] stream_offset;
    logic        fin_flag;
    logic [15:0] payload_length;
    logic [16:0] buffer_room;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_byte;
    logic [1:0]  status;
    logic [16:0] frame_length;
  } out_item_t;

  // one queued job: a ready-made result, or a header of up to four varint fields
  typedef struct packed {
    logic                 hdr;
    logic [1:0]           last_fld;
    logic [3:0][1:0]      codes;
    logic [3:0][63:0]     vals;
    logic                 end_last;
    logic [16:0]          total;
    out_item_t            single;
  } qsfe_job_t;

  // {ok, length code}
  function automatic logic [2:0] vi_code(input logic [63:0] v);
    logic [2:0] r;
    if (v < 64'd64) begin
      r = 3'b100;
    end else if (v < 64'd16384) begin
      r = 3'b101;
    end else if (v < 64'h4000_0000) begin
      r = 3'b110;
    end else if (v <= VARINT_MAX) begin
      r = 3'b111;
    end else begin
      r = 3'b000;
    end
    return r;
  endfunction

  function automatic logic [3:0] vi_len(input logic [1:0] code);
    return 4'd1 << code;
  endfunction

endpackage

`default_nettype wire

// ===== design/qsfe_front.sv =====
// ----------------------------------------------------------------------------
// qsfe_front
// Accepts commands, checks varint limits and room, tracks payload state and
// turns each item into a queued job, except payload bytes of a rejected frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qsfe_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  accept,
  input  qsfe_pkg::in_item_t   item,
  output logic                 push,
  output qsfe_pkg::qsfe_job_t  job
);
  import qsfe_pkg::*;

  logic [15:0] rem_r, rem_nxt;
  logic        drop_r, drop_nxt;
  logic [16:0] ftot_r, ftot_nxt;
  logic        want_push;

  logic [15:0] len;
  logic [2:0]  vc_sid, vc_err, vc_fsz, vc_off, vc_len;
  logic        off_nz;
  logic [16:0] tot_ctl, tot_str;
  logic        ok_ctl, ok_str;
  logic [7:0]  stype;
  out_item_t   err_item;

  assign len    = item.payload_length & LEN_MASK;
  assign vc_sid = vi_code(item.strm_id);
  assign vc_err = vi_code(item.app_err);
  assign vc_fsz = vi_code(item.final_sz);
  assign vc_off = vi_code(item.stream_offset);
  assign vc_len = vi_code({48'd0, len});
  assign off_nz = (item.stream_offset != 64'd0);

  assign ok_ctl = vc_sid[2] && vc_err[2] &&
                  (vc_fsz[2] || (qsfe_cmd_t'(item.command) != CMD_RST_STRM));
  assign ok_str = vc_sid[2] && vc_len[2] && (vc_off[2] || !off_nz);

  assign tot_ctl = 17'd1 + 17'(vi_len(vc_sid[1:0])) + 17'(vi_len(vc_err[1:0])) +
                   ((qsfe_cmd_t'(item.command) == CMD_RST_STRM) ?
                    17'(vi_len(vc_fsz[1:0])) : 17'd0);
  assign tot_str = 17'd1 + 17'(vi_len(vc_sid[1:0])) +
                   (off_nz ? 17'(vi_len(vc_off[1:0])) : 17'd0) +
                   17'(vi_len(vc_len[1:0])) + {1'b0, len};

  assign stype = TYPE_STREAM | TYPE_BIT_LEN | {7'd0, item.fin_flag} |
                 (off_nz ? TYPE_BIT_OFF : 8'd0);

  always_comb begin
    rem_nxt   = rem_r;
    drop_nxt  = drop_r;
    ftot_nxt  = ftot_r;
    want_push = 1'b0;
    job       = '0;
    err_item  = '0;
    err_item.last_byte = 1'b1;
    unique case (qsfe_cmd_t'(item.command))
      CMD_PAYLOAD: begin
        if (rem_r == 16'd0) begin
          want_push = 1'b1;
          job.single = err_item;
          job.single.status = ST_STRAY;
        end else begin
          rem_nxt = rem_r - 16'd1;
          if (drop_r) begin
            drop_nxt = (rem_r != 16'd1);
          end else begin
            want_push = 1'b1;
            job.single.out_byte     = item.payload_byte;
            job.single.last_byte    = (rem_r == 16'd1);
            job.single.status       = ST_OK;
            job.single.frame_length = (rem_r == 16'd1) ? ftot_r : 17'd0;
          end
        end
      end
      CMD_RST_STRM, CMD_STOP_SEND: begin
        rem_nxt   = 16'd0;
        drop_nxt  = 1'b0;
        ftot_nxt  = 17'd0;
        want_push = 1'b1;
        if (!ok_ctl) begin
          job.single = err_item;
          job.single.status = ST_TOO_LARGE;
        end else if (item.buffer_room < tot_ctl) begin
          job.single = err_item;
          job.single.status = ST_NO_ROOM;
        end else begin
          job.hdr      = 1'b1;
          job.end_last = 1'b1;
          job.total    = tot_ctl;
          job.vals[0]  = {56'd0, (qsfe_cmd_t'(item.command) == CMD_RST_STRM) ?
                          TYPE_RST_STRM : TYPE_STOP_SEND};
          job.vals[1]  = item.strm_id;
          job.codes[1] = vc_sid[1:0];
          job.vals[2]  = item.app_err;
          job.codes[2] = vc_err[1:0];
          job.vals[3]  = item.final_sz;
          job.codes[3] = vc_fsz[1:0];
          job.last_fld = (qsfe_cmd_t'(item.command) == CMD_RST_STRM) ? 2'd3 : 2'd2;
        end
      end
      CMD_STREAM_HDR: begin
        rem_nxt   = len;
        drop_nxt  = 1'b0;
        ftot_nxt  = 17'd0;
        want_push = 1'b1;
        if (!ok_str || (item.buffer_room < tot_str)) begin
          // rejected frame: swallow its payload quietly
          drop_nxt   = (len != 16'd0);
          job.single = err_item;
          job.single.status = ok_str ? ST_NO_ROOM : ST_TOO_LARGE;
        end else begin
          ftot_nxt     = (len != 16'd0) ? tot_str : 17'd0;
          job.hdr      = 1'b1;
          job.end_last = (len == 16'd0);
          job.total    = tot_str;
          job.vals[0]  = {56'd0, stype};
          job.vals[1]  = item.strm_id;
          job.codes[1] = vc_sid[1:0];
          if (off_nz) begin
            job.vals[2]  = item.stream_offset;
            job.codes[2] = vc_off[1:0];
            job.vals[3]  = {48'd0, len};
            job.codes[3] = vc_len[1:0];
            job.last_fld = 2'd3;
          end else begin
            job.vals[2]  = {48'd0, len};
            job.codes[2] = vc_len[1:0];
            job.last_fld = 2'd2;
          end
        end
      end
      default: begin
        want_push = 1'b0;
      end
    endcase
  end

  assign push = accept && want_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= 16'd0;
      drop_r <= 1'b0;
      ftot_r <= 17'd0;
    end else if (accept) begin
      rem_r  <= rem_nxt;
      drop_r <= drop_nxt;
      ftot_r <= ftot_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/qsfe_queue.sv =====
// ----------------------------------------------------------------------------
// qsfe_queue
// Short job queue between the classifying front and the byte serialiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qsfe_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  qsfe_pkg::qsfe_job_t  push_job,
  input  wire                  pop,
  output qsfe_pkg::qsfe_job_t  head,
  output logic                 not_empty,
  output logic                 full
);
  import qsfe_pkg::*;

  qsfe_job_t       slot_r [QUEUE_DEPTH];
  logic [QA_W-1:0] wp_r, rp_r;
  logic [QC_W-1:0] cnt_r, cnt_nxt;

  assign head      = slot_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == QC_W'(QUEUE_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/qsfe_back.sv =====
// ----------------------------------------------------------------------------
// qsfe_back
// Serialises queued jobs into output beats, one varint byte per cycle while the
// output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qsfe_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  qsfe_pkg::qsfe_job_t  head,
  input  wire                  not_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output qsfe_pkg::out_item_t  out_data
);
  import qsfe_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;
  logic [1:0] fld_r, fld_nxt;
  logic [2:0] idx_r, idx_nxt;

  logic        adv;
  logic [1:0]  code;
  logic [2:0]  sm1, sel;
  logic [63:0] val;
  logic [7:0]  vbyte;
  logic        fld_end, job_end, ends_frame;

  assign adv  = !out_valid_r || !out_stall;
  assign code = head.codes[fld_r];
  assign sm1  = 3'(vi_len(code) - 4'd1);
  assign sel  = sm1 - idx_r;
  assign val  = head.vals[fld_r];

  // big-endian varint byte, length code in the top bits of the first one
  always_comb begin
    vbyte = 8'(val >> {sel, 3'b000});
    if (idx_r == 3'd0) begin
      vbyte = vbyte | {code, 6'd0};
    end
  end

  assign fld_end    = (idx_r == sm1);
  assign job_end    = fld_end && (fld_r == head.last_fld);
  assign ends_frame = job_end && head.end_last;
  assign pop        = adv && not_empty && (!head.hdr || job_end);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    fld_nxt       = fld_r;
    idx_nxt       = idx_r;
    if (adv) begin
      out_valid_nxt = not_empty;
      if (not_empty) begin
        if (!head.hdr) begin
          out_nxt = head.single;
        end else begin
          out_nxt.out_byte     = vbyte;
          out_nxt.last_byte    = ends_frame;
          out_nxt.status       = ST_OK;
          out_nxt.frame_length = ends_frame ? head.total : 17'd0;
          if (job_end) begin
            fld_nxt = 2'd0;
            idx_nxt = 3'd0;
          end else if (fld_end) begin
            fld_nxt = fld_r + 2'd1;
            idx_nxt = 3'd0;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fld_r       <= 2'd0;
      idx_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      fld_r       <= fld_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== design/quic_stream_frame_encoder.sv =====
// path: a taken item is written into the job queue, and the back end then registers
// its first result beat in the output stage. Throughput: payload bytes at one per cycle
// while the output is not stalled; a header (3 to 25 encoded bytes) is serialised byte
// by byte by the back end from a 4-entry job queue; input stalls only while it is full
// reset: synchronous, active low; clears payload count, drop flag, frame total, queue
// and output valid
// ----------------------------------------------------------------------------
// quic_stream_frame_encoder
// Encodes stream reset, stop-sending and stream headers as varint byte
// streams and passes stream payload bytes through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quic_stream_frame_encoder (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  qsfe_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output qsfe_pkg::out_item_t  out_data
);
  import qsfe_pkg::*;

  logic      accept, push, pop, not_empty, full;
  qsfe_job_t job, head;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  qsfe_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .push   (push),
    .job    (job)
  );

  qsfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (job),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  qsfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/qsfe_checker.sv =====
// ----------------------------------------------------------------------------
// qsfe_checker
// Port-level checks on the stream frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "quic_stream_frame_encoder_assert.svh"

module qsfe_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_stall,
  input wire                  out_valid,
  input wire                  out_stall,
  input qsfe_pkg::out_item_t  out_data
);
  import qsfe_pkg::*;

  logic err_beat, err_beat_ok, ok_beat, len_on_close;

  // an error beat is a lone closing beat with no byte and no length
  assign err_beat     = out_valid && (out_data.status != ST_OK);
  assign err_beat_ok  = out_data.last_byte && (out_data.out_byte == 8'd0) &&
                        (out_data.frame_length == 17'd0);
  // the frame length shows on the closing beat only
  assign ok_beat      = out_valid && (out_data.status == ST_OK);
  assign len_on_close = (out_data.last_byte == (out_data.frame_length != 17'd0));

  // nothing left over and input open once reset has been applied
  `QSFE_ASSERT_RST(a_rst_clears, clk, !rst_n |=> !out_valid && !in_stall, "busy after reset")

  `QSFE_ASSERT(a_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled beat changed")

  `QSFE_ASSERT(a_err_shape, clk, rst_n, err_beat |-> err_beat_ok, "bad error beat")

  `QSFE_ASSERT(a_len_shape, clk, rst_n, ok_beat |-> len_on_close, "frame length on wrong beat")

endmodule

bind quic_stream_frame_encoder qsfe_checker u_qsfe_checker (.*);

`default_nettype wire

// ===== tb/quic_stream_frame_encoder_test.sv =====
// ----------------------------------------------------------------------------
// quic_stream_frame_encoder_test
// Self-checking bench for the stream frame encoder. A directed table covers
// field extremes, every command and the error paths; random frames with
// random payload runs follow. Each accepted beat is predicted in the bench
// and compared field by field against the encoder output, with random gaps
// on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quic_stream_frame_encoder_test;
  import qsfe_pkg::*;

  localparam logic [63:0] VMAX     = VARINT_MAX;
  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [16:0] ROOM_MAX = 17'd65560;
  localparam out_item_t   NONE     = '0;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // bench copy of the encoder state
  logic [15:0] data_left;
  bit          discarding;
  logic [16:0] open_frame_len;

  out_item_t   owed_beats[$];
  out_item_t   step_beats[$];
  logic [7:0]  hdr_bytes[$];
  dir_row_t    dir_rows[$];

  int mismatches = 0;
  int sent_items = 0;
  int hold_left = 0;
  bit quiet = 1'b0;

  quic_stream_frame_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int vi_bytes(input logic [63:0] v);
    if (v < 64'd64) return 1;
    if (v < 64'd16384) return 2;
    if (v < 64'h4000_0000) return 4;
    if (v <= VMAX) return 8;
    return 0;
  endfunction

  function automatic void put_varint(input logic [63:0] v);
    int n;
    logic [1:0] code;
    logic [7:0] b;
    n = vi_bytes(v);
    code = (n == 1) ? 2'd0 : (n == 2) ? 2'd1 : (n == 4) ? 2'd2 : 2'd3;
    for (int i = 0; i < n; i++) begin
      b = 8'(v >> (8 * (n - 1 - i)));
      if (i == 0) b[7:6] = code;
      hdr_bytes.push_back(b);
    end
  endfunction

  function automatic out_item_t beat(input logic [7:0] b, input logic last,
                                     input qsfe_status_t st, input logic [16:0] flen);
    out_item_t r;
    r.out_byte = b;
    r.last_byte = last;
    r.status = st;
    r.frame_length = flen;
    return r;
  endfunction

  function automatic out_item_t fault(input qsfe_status_t st);
    return beat(8'h00, 1'b1, st, 17'd0);
  endfunction

  // header bytes after a successful check, last flag on the final one if asked
  function automatic void emit_header(input int total, input bit ends_frame);
    bit fin_here;
    foreach (hdr_bytes[i]) begin
      fin_here = ends_frame && (i == hdr_bytes.size() - 1);
      step_beats.push_back(beat(hdr_bytes[i], fin_here, ST_OK,
                                fin_here ? 17'(total) : 17'd0));
    end
  endfunction

  // expected beats of one accepted input beat, into step_beats
  function automatic void encode_item(input in_item_t it);
    int a, b, c, o, l, total;
    bit off_nz, is_reset;
    logic [15:0] len;
    logic [7:0] ftype;
    qsfe_cmd_t cmd;

    cmd = qsfe_cmd_t'(it.command);
    if (cmd == CMD_PAYLOAD) begin
      if (data_left == 0) begin
        step_beats.push_back(fault(ST_STRAY));
        return;
      end
      data_left--;
      if (discarding) begin
        if (data_left == 0) discarding = 1'b0;
        return;
      end
      step_beats.push_back(beat(it.payload_byte, data_left == 0, ST_OK,
                                (data_left == 0) ? open_frame_len : 17'd0));
      return;
    end

    // any header drops whatever payload was still owed
    data_left = '0;
    discarding = 1'b0;
    open_frame_len = '0;
    hdr_bytes.delete();

    if (cmd == CMD_RST_STRM || cmd == CMD_STOP_SEND) begin
      is_reset = (cmd == CMD_RST_STRM);
      a = vi_bytes(it.strm_id);
      b = vi_bytes(it.app_err);
      c = is_reset ? vi_bytes(it.final_sz) : 1;
      if (a == 0 || b == 0 || c == 0) begin
        step_beats.push_back(fault(ST_TOO_LARGE));
        return;
      end
      total = 1 + a + b + (is_reset ? c : 0);
      if (int'(it.buffer_room) < total) begin
        step_beats.push_back(fault(ST_NO_ROOM));
        return;
      end
      hdr_bytes.push_back(is_reset ? TYPE_RST_STRM : TYPE_STOP_SEND);
      put_varint(it.strm_id);
      put_varint(it.app_err);
      if (is_reset) put_varint(it.final_sz);
      emit_header(total, 1'b1);
      return;
    end

    len = it.payload_length & LEN_MASK;
    off_nz = (it.stream_offset != 0);
    a = vi_bytes(it.strm_id);
    l = vi_bytes(64'(len));
    o = off_nz ? vi_bytes(it.stream_offset) : 1;
    total = 1 + a + (off_nz ? o : 0) + l + int'(len);
    if (a == 0 || l == 0 || o == 0 || int'(it.buffer_room) < total) begin
      // rejected frame: its payload is swallowed without results
      data_left = len;
      discarding = (len != 0);
      step_beats.push_back(fault((a == 0 || l == 0 || o == 0) ? ST_TOO_LARGE : ST_NO_ROOM));
      return;
    end
    ftype = TYPE_STREAM | TYPE_BIT_LEN | {7'd0, it.fin_flag} | (off_nz ? TYPE_BIT_OFF : 8'h00);
    hdr_bytes.push_back(ftype);
    put_varint(it.strm_id);
    if (off_nz) put_varint(it.stream_offset);
    put_varint(64'(len));
    emit_header(total, len == 0);
    data_left = len;
    open_frame_len = (len != 0) ? 17'(total) : 17'd0;
  endfunction

  function automatic in_item_t mk(input qsfe_cmd_t cmd, input logic [63:0] sid,
                                  input logic [63:0] err, input logic [63:0] fsz,
                                  input logic [63:0] off, input logic fin,
                                  input logic [15:0] len, input logic [16:0] room,
                                  input logic [7:0] pb);
    in_item_t it;
    it.command = cmd;
    it.strm_id = sid;
    it.app_err = err;
    it.final_sz = fsz;
    it.stream_offset = off;
    it.fin_flag = fin;
    it.payload_length = len;
    it.buffer_room = room;
    it.payload_byte = pb;
    return it;
  endfunction

  function automatic in_item_t noise_item(input qsfe_cmd_t cmd);
    return mk(cmd, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, 1'($urandom), 16'($urandom),
              17'($urandom_range(0, 65560)), 8'($urandom));
  endfunction

  // values spread over the four varint sizes, the size edges and too-large ones
  function automatic logic [63:0] rand_varint();
    logic [63:0] raw;
    logic [63:0] edges[8];
    int r;
    edges = '{64'd63, 64'd64, 64'd16383, 64'd16384, 64'h3FFF_FFFF, 64'h4000_0000,
              VMAX, VMAX + 64'd1};
    raw = {$urandom, $urandom};
    r = $urandom_range(0, 19);
    if (r < 5) return raw & 64'h3F;
    if (r < 9) return raw & 64'h3FFF;
    if (r < 12) return raw & 64'h3FFF_FFFF;
    if (r < 16) return raw & VMAX;
    if (r < 18) return edges[$urandom_range(0, 7)];
    return raw | (64'd1 << $urandom_range(62, 63));
  endfunction

  function automatic logic [16:0] pick_room(input int need);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 17'((need + 20 > 65560) ? 65560 : need + $urandom_range(0, 20));
    if (r < 90) return 17'(need - 1);
    return 17'($urandom_range(0, 65560));
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_beat(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_beats.delete();
    encode_item(it);
    sent_items++;
    if (typed) begin
      owed_beats.push_back(want);
    end else begin
      foreach (step_beats[i]) owed_beats.push_back(step_beats[i]);
    end
  endtask

  task automatic send_stream_frame();
    in_item_t it;
    int a, o, l, need, n_data, r;
    it = noise_item(CMD_STREAM_HDR);
    it.strm_id = rand_varint();
    it.stream_offset = ($urandom_range(0, 9) < 4) ? 64'd0 : rand_varint();
    r = $urandom_range(0, 99);
    if (r < 60) it.payload_length = 16'($urandom_range(0, 6));
    else if (r < 85) it.payload_length = 16'($urandom_range(7, 40));
    a = vi_bytes(it.strm_id);
    o = (it.stream_offset != 0) ? vi_bytes(it.stream_offset) : 1;
    l = vi_bytes(64'(it.payload_length));
    need = 1 + a + ((it.stream_offset != 0) ? o : 0) + l + int'(it.payload_length);
    if (a != 0 && o != 0) it.buffer_room = pick_room(need);
    send_beat(it, 1'b0, NONE);
    // mostly the full run; sometimes cut short, or one byte too many
    r = $urandom_range(0, 99);
    if (it.payload_length > 40) n_data = $urandom_range(0, 6);
    else if (r < 85) n_data = it.payload_length;
    else if (r < 93 && it.payload_length > 0) n_data = $urandom_range(0, it.payload_length - 1);
    else n_data = it.payload_length + 1;
    repeat (n_data) send_beat(noise_item(CMD_PAYLOAD), 1'b0, NONE);
  endtask

  task automatic send_control_frame();
    in_item_t it;
    int a, b, c;
    bit is_reset;
    is_reset = ($urandom_range(0, 1) == 0);
    it = noise_item(is_reset ? CMD_RST_STRM : CMD_STOP_SEND);
    it.strm_id = rand_varint();
    it.app_err = rand_varint();
    it.final_sz = rand_varint();
    a = vi_bytes(it.strm_id);
    b = vi_bytes(it.app_err);
    c = is_reset ? vi_bytes(it.final_sz) : 1;
    if (a != 0 && b != 0 && c != 0) it.buffer_room = pick_room(1 + a + b + (is_reset ? c : 0));
    send_beat(it, 1'b0, NONE);
  endtask

  // output side: random stalls, short runs mostly and the odd long one
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_stall <= 1'b0;
      end else begin
        hold_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(7, 39);
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: byte %02h last %0b status %0d len %0d",
                   out_data.out_byte, out_data.last_byte, out_data.status,
                   out_data.frame_length);
      end else begin
        want = owed_beats.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.last_byte !== want.last_byte ||
            out_data.status !== want.status || out_data.frame_length !== want.frame_length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: want byte %02h last %0b status %0d len %0d, ",
                     want.out_byte, want.last_byte, want.status, want.frame_length,
                     "got byte %02h last %0b status %0d len %0d",
                     out_data.out_byte, out_data.last_byte, out_data.status,
                     out_data.frame_length);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int r;
    data_left = '0;
    discarding = 1'b0;
    open_frame_len = '0;

    // nothing open yet
    dir_rows.push_back('{mk(CMD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0, 8'hFF), 1, fault(ST_STRAY)});
    dir_rows.push_back('{mk(CMD_RST_STRM, 0, 0, 0, 0, 0, 0, 17'd4, 0), 0, NONE});
    // longest frame: three 8-byte varints
    dir_rows.push_back('{mk(CMD_RST_STRM, VMAX, VMAX, VMAX, 0, 0, 0, ROOM_MAX, 0), 0, NONE});
    dir_rows.push_back('{mk(CMD_RST_STRM, VMAX + 1, 0, 0, 0, 0, 0, ROOM_MAX, 0), 1,
                         fault(ST_TOO_LARGE)});
    // too large wins over no room
    dir_rows.push_back('{mk(CMD_STOP_SEND, 0, ALL_ONES, 0, 0, 1, 0, 17'd0, 0), 1,
                         fault(ST_TOO_LARGE)});
    // final size is ignored for a stop-sending frame
    dir_rows.push_back('{mk(CMD_STOP_SEND, 63, 64, ALL_ONES, 0, 0, 0, 17'd4, 0), 0, NONE});
    dir_rows.push_back('{mk(CMD_STOP_SEND, 16383, 16384, 0, 0, 0, 0, 17'd0, 0), 1,
                         fault(ST_NO_ROOM)});
    // empty stream frame ends on its header
    dir_rows.push_back('{mk(CMD_STREAM_HDR, 0, 0, 0, 0, 0, 0, 17'd3, 0), 0, NONE});
    dir_rows.push_back('{mk(CMD_STREAM_HDR, 37, 0, 0, 64'h3FFF_FFFF, 1, 2, ROOM_MAX, 0), 0,
                         NONE});
    dir_rows.push_back('{mk(CMD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0, 8'h00), 0, NONE});
    dir_rows.push_back('{mk(CMD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0, 8'hFF), 0, NONE});
    dir_rows.push_back('{mk(CMD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0, 8'hA5), 1, fault(ST_STRAY)});
    // rejected frame: its two data bytes vanish
    dir_rows.push_back('{mk(CMD_STREAM_HDR, 5, 0, 0, ALL_ONES, 0, 2, ROOM_MAX, 0), 1,
                         fault(ST_TOO_LARGE)});
    dir_rows.push_back('{mk(CMD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0, 8'h11), 0, NONE});
    dir_rows.push_back('{mk(CMD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0, 8'h22), 0, NONE});
    dir_rows.push_back('{mk(CMD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0, 8'h33), 1, fault(ST_STRAY)});
    dir_rows.push_back('{mk(CMD_STREAM_HDR, 0, 0, 0, 0, 1, 16'hFFFF, 17'd65535, 0), 1,
                         fault(ST_NO_ROOM)});
    dir_rows.push_back('{mk(CMD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0, 8'h44), 0, NONE});
    // header in the middle of a discarded run clears it
    dir_rows.push_back('{mk(CMD_RST_STRM, 1, 2, 3, 0, 0, 0, 17'd4, 0), 0, NONE});
    dir_rows.push_back('{mk(CMD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0, 8'h55), 1, fault(ST_STRAY)});
    dir_rows.push_back('{mk(CMD_STREAM_HDR, VMAX, 0, 0, VMAX, 1, 0, 17'd18, 0), 0, NONE});
    dir_rows.push_back('{mk(CMD_STREAM_HDR, 0, 0, 0, 0, 0, 1, 17'd4, 0), 0, NONE});
    dir_rows.push_back('{mk(CMD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0, 8'h80), 0, NONE});
    // header in the middle of a live run abandons it
    dir_rows.push_back('{mk(CMD_STREAM_HDR, 9, 0, 0, 0, 0, 5, 17'd100, 0), 0, NONE});
    dir_rows.push_back('{mk(CMD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0, 8'h7F), 0, NONE});
    dir_rows.push_back('{mk(CMD_STOP_SEND, 2, 3, 0, 0, 0, 0, 17'd3, 0), 0, NONE});
    dir_rows.push_back('{mk(CMD_PAYLOAD, 0, 0, 0, 0, 0, 0, 0, 8'h01), 1, fault(ST_STRAY)});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    while (sent_items < 220) begin
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
      r = $urandom_range(0, 99);
      if (r < 65) send_stream_frame();
      else if (r < 90) send_control_frame();
      else send_beat(noise_item(CMD_PAYLOAD), 1'b0, NONE);
    end
    in_valid <= 1'b0;

    while (owed_beats.size() != 0) @(posedge clk);
    // a few spare cycles to catch any stray extra beat
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
